// File: sv/hex_record_loader_core_assert.svh
// Assertion macros for the hex record loader core.
// Used by hex_record_loader_core.sv; expects clk and rst_n in scope.
`ifndef HEX_RECORD_LOADER_CORE_ASSERT_SVH
`define HEX_RECORD_LOADER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define HRL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define HRL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/hrl_pkg.sv
// Shared constants for the hex record loader core.
// No dependencies; imported by hex_record_loader_core.
package hrl_pkg;

  // Default memory size in bytes (up to 2^32, hence 33 bits)
  localparam logic [32:0] HRL_MEM_BYTES = 33'd16777216;

  // Characters with a meaning of their own
  localparam logic [7:0] HRL_CHAR_COLON = 8'h3A;
  localparam logic [7:0] HRL_CHAR_LF    = 8'h0A;
  localparam logic [7:0] HRL_CHAR_CR    = 8'h0D;

  // Record types
  localparam logic [7:0] HRL_REC_DATA    = 8'h00;
  localparam logic [7:0] HRL_REC_SEG_ADR = 8'h02;
  localparam logic [7:0] HRL_REC_SEG_PC  = 8'h03;
  localparam logic [7:0] HRL_REC_LIN_ADR = 8'h04;
  localparam logic [7:0] HRL_REC_LIN_PC  = 8'h05;

  // Line positions of field boundaries (colon is position 0)
  localparam logic [9:0] HRL_POS_LEN_HI  = 10'd1;
  localparam logic [9:0] HRL_POS_LEN_LO  = 10'd2;
  localparam logic [9:0] HRL_POS_ADR_HI  = 10'd3;
  localparam logic [9:0] HRL_POS_ADR_LO  = 10'd6;
  localparam logic [9:0] HRL_POS_TYP_HI  = 10'd7;
  localparam logic [9:0] HRL_POS_TYP_LO  = 10'd8;
  localparam logic [9:0] HRL_POS_DATA    = 10'd9;
  localparam logic [9:0] HRL_POS_BYTE0   = 10'd10;
  localparam logic [9:0] HRL_POS_ADR_END = 10'd12;
  localparam logic [9:0] HRL_POS_PC_END  = 10'd16;
  localparam logic [9:0] HRL_POS_MAX     = 10'd1023;

  // Decoded hex digit: valid flag and value
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hrl_digit_t;

endpackage

// File: sv/hex_record_loader_core.sv
// Intel HEX record decoder core, one text character per transfer.
// Depends on hrl_pkg and hex_record_loader_core_assert.svh.

// The core takes one character per cycle while in_stall is low and gives one
// result per character from its output register. The path is an input register of one
// entry followed by the decode logic and an output register; the input
// register lets the core take a character while a result waits on a stalled
// output, so the sustained rate is one character per clock whenever the
// output side keeps up. The record state (line position, length, address,
// type, digit shift register, segment base, linear offset, start PC) is
// updated as a character moves from the input register to the output
// register. Writes at or beyond MEM_BYTES are suppressed; write_addr carries
// the low 24 bits of the byte address.
module hex_record_loader_core #(
  parameter logic [32:0] MEM_BYTES = hrl_pkg::HRL_MEM_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_write_en,
  output logic [23:0] out_write_addr,
  output logic [7:0]  out_write_byte,
  output logic [31:0] out_start_pc,
  output logic        out_start_pc_set,
  output logic        out_offset_zero,
  output logic        out_bad_digit
);
  import hrl_pkg::*;

  `include "hex_record_loader_core_assert.svh"

  // Input register
  logic        in_vld_r;
  logic [7:0]  in_char_r;

  // Record state
  logic [9:0]  char_pos_r,  char_pos_nxt;
  logic        in_rec_r,    in_rec_nxt;
  logic        dropped_r,   dropped_nxt;
  logic [7:0]  rec_len_r,   rec_len_nxt;
  logic [15:0] rec_addr_r,  rec_addr_nxt;
  logic [7:0]  rec_kind_r,  rec_kind_nxt;
  logic [31:0] acc_r,       acc_nxt;
  logic [19:0] seg_base_r,  seg_base_nxt;
  logic [31:0] lin_off_r,   lin_off_nxt;
  logic [31:0] prog_pc_r,   prog_pc_nxt;

  // Output register
  logic        out_valid_r;
  logic        out_write_en_r,     wen_nxt;
  logic [23:0] out_write_addr_r,   waddr_nxt;
  logic [7:0]  out_write_byte_r,   wbyte_nxt;
  logic [31:0] out_start_pc_r;
  logic        out_start_pc_set_r, pcset_nxt;
  logic        out_offset_zero_r;
  logic        out_bad_digit_r,    bad_nxt;

  logic        adv;
  hrl_digit_t  dig;
  logic [9:0]  pos_m10;
  logic [8:0]  byte_idx;
  logic [31:0] wr_addr;

  // Map an ASCII character to a hex digit
  function automatic hrl_digit_t hex_digit(input logic [7:0] c);
    hrl_digit_t d;
    d.ok  = 1'b1;
    d.val = 4'd0;
    case (c) inside
      [8'h30:8'h39]: d.val = 4'(c - 8'h30);
      [8'h41:8'h46]: d.val = 4'(c - 8'h37);
      [8'h61:8'h66]: d.val = 4'(c - 8'h57);
      default:       d.ok  = 1'b0;
    endcase
    return d;
  endfunction

  // Move the held character on when the output register is free or drains
  assign adv      = in_vld_r && (!out_valid_r || !out_stall);
  assign in_stall = in_vld_r && !adv;

  // Byte index and write address of a data digit pair
  assign dig      = hex_digit(in_char_r);
  assign pos_m10  = char_pos_r - HRL_POS_BYTE0;
  assign byte_idx = pos_m10[9:1];
  assign wr_addr  = {16'd0, rec_addr_r} + {12'd0, seg_base_r} + lin_off_r
                  + {23'd0, byte_idx};

  // Decode one character against the record state
  always_comb begin
    char_pos_nxt = char_pos_r;
    in_rec_nxt   = in_rec_r;
    dropped_nxt  = dropped_r;
    rec_len_nxt  = rec_len_r;
    rec_addr_nxt = rec_addr_r;
    rec_kind_nxt = rec_kind_r;
    acc_nxt      = acc_r;
    seg_base_nxt = seg_base_r;
    lin_off_nxt  = lin_off_r;
    prog_pc_nxt  = prog_pc_r;
    wen_nxt      = 1'b0;
    waddr_nxt    = 24'd0;
    wbyte_nxt    = 8'd0;
    pcset_nxt    = 1'b0;
    bad_nxt      = 1'b0;

    if (in_char_r == HRL_CHAR_LF || in_char_r == HRL_CHAR_CR) begin
      char_pos_nxt = 10'd0;
      in_rec_nxt   = 1'b0;
      dropped_nxt  = 1'b0;
    end else if (char_pos_r == 10'd0) begin
      in_rec_nxt   = (in_char_r == HRL_CHAR_COLON);
      char_pos_nxt = 10'd1;
    end else begin
      if (in_rec_r && !dropped_r) begin
        if (!dig.ok) begin
          bad_nxt     = 1'b1;
          dropped_nxt = 1'b1;
        end else begin
          // Restart the shift register at the first digit of each field
          if (char_pos_r inside {HRL_POS_LEN_HI, HRL_POS_ADR_HI, HRL_POS_TYP_HI,
                                 HRL_POS_DATA}) begin
            acc_nxt = {28'd0, dig.val};
          end else begin
            acc_nxt = {acc_r[27:0], dig.val};
          end

          if (char_pos_r == HRL_POS_LEN_LO) begin
            rec_len_nxt = acc_nxt[7:0];
          end else if (char_pos_r == HRL_POS_ADR_LO) begin
            rec_addr_nxt = acc_nxt[15:0];
          end else if (char_pos_r == HRL_POS_TYP_LO) begin
            rec_kind_nxt = acc_nxt[7:0];
          end else if (char_pos_r >= HRL_POS_DATA) begin
            case (rec_kind_r)
              HRL_REC_DATA: begin
                // Second digit of a byte within the count: emit a write
                if (!pos_m10[0] && (byte_idx < {1'b0, rec_len_r})) begin
                  if ({1'b0, wr_addr} < MEM_BYTES) begin
                    wen_nxt   = 1'b1;
                    waddr_nxt = wr_addr[23:0];
                    wbyte_nxt = acc_nxt[7:0];
                  end
                end
              end
              HRL_REC_SEG_ADR: begin
                if (char_pos_r == HRL_POS_ADR_END) begin
                  seg_base_nxt = {acc_nxt[15:0], 4'd0};
                end
              end
              HRL_REC_LIN_ADR: begin
                if (char_pos_r == HRL_POS_ADR_END) begin
                  lin_off_nxt  = {acc_nxt[15:0], 16'd0};
                  seg_base_nxt = 20'd0;
                end
              end
              HRL_REC_SEG_PC: begin
                if (char_pos_r == HRL_POS_PC_END) begin
                  prog_pc_nxt = {12'd0, acc_nxt[31:16], 4'd0} + {16'd0, acc_nxt[15:0]};
                  pcset_nxt   = 1'b1;
                end
              end
              HRL_REC_LIN_PC: begin
                if (char_pos_r == HRL_POS_PC_END) begin
                  prog_pc_nxt = acc_nxt;
                  pcset_nxt   = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      // Advance the position, saturating on very long lines
      if (char_pos_r != HRL_POS_MAX) begin
        char_pos_nxt = char_pos_r + 10'd1;
      end
    end
  end

  // Hold the accepted character until it moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_char_r <= in_char_in;
    end
  end

  // Update record state as a character moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_pos_r <= 10'd0;
      in_rec_r   <= 1'b0;
      dropped_r  <= 1'b0;
      rec_len_r  <= 8'd0;
      rec_addr_r <= 16'd0;
      rec_kind_r <= 8'd0;
      acc_r      <= 32'd0;
      seg_base_r <= 20'd0;
      lin_off_r  <= 32'd0;
      prog_pc_r  <= 32'd0;
    end else if (adv) begin
      char_pos_r <= char_pos_nxt;
      in_rec_r   <= in_rec_nxt;
      dropped_r  <= dropped_nxt;
      rec_len_r  <= rec_len_nxt;
      rec_addr_r <= rec_addr_nxt;
      rec_kind_r <= rec_kind_nxt;
      acc_r      <= acc_nxt;
      seg_base_r <= seg_base_nxt;
      lin_off_r  <= lin_off_nxt;
      prog_pc_r  <= prog_pc_nxt;
    end
  end

  // Output register: load on advance, drop valid once the result transfers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r        <= 1'b0;
      out_write_en_r     <= 1'b0;
      out_start_pc_set_r <= 1'b0;
      out_bad_digit_r    <= 1'b0;
    end else if (adv) begin
      out_valid_r        <= 1'b1;
      out_write_en_r     <= wen_nxt;
      out_start_pc_set_r <= pcset_nxt;
      out_bad_digit_r    <= bad_nxt;
    end else if (!out_stall) begin
      out_valid_r        <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_write_addr_r  <= waddr_nxt;
      out_write_byte_r  <= wbyte_nxt;
      out_start_pc_r    <= prog_pc_nxt;
      out_offset_zero_r <= (lin_off_nxt == 32'd0);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_en     = out_write_en_r;
  assign out_write_addr   = out_write_addr_r;
  assign out_write_byte   = out_write_byte_r;
  assign out_start_pc     = out_start_pc_r;
  assign out_start_pc_set = out_start_pc_set_r;
  assign out_offset_zero  = out_offset_zero_r;
  assign out_bad_digit    = out_bad_digit_r;

  // Checks on the decode and the two-register path
  `HRL_ASSERT_NXT(a_adv_loads_out, adv, out_valid_r, "advance did not load output")
  `HRL_ASSERT_NOW(a_write_in_range, out_write_en_r,
    ({9'd0, out_write_addr_r} < MEM_BYTES), "write beyond memory")
  `HRL_ASSERT_NOW(a_write_not_pc, out_write_en_r, !out_start_pc_set_r, "write and start PC together")
  `HRL_ASSERT_NOW(a_bad_no_action, out_bad_digit_r,
    !out_write_en_r && !out_start_pc_set_r, "action on bad digit")
  `HRL_ASSERT_NOW(a_line_start_clean, char_pos_r == 10'd0, !dropped_r && !in_rec_r,
    "line start carries state")

endmodule
